// File: hw/rtl/tlpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpt_pkg: shared constants for the two-level page table with copy-on-write
// address split, entry flag positions, action and status codes
// ----------------------------------------------------------------------------
package tlpt_pkg;

    // address split: directory (31..22), table index (21..12), offset (11..0)
    localparam int DIR_SHIFT         = 22;
    localparam int IDX_W             = 10;
    localparam int OFFSET_W          = 12;
    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int DEF_TABLES        = 32;

    // entry flag positions
    localparam int BIT_PRESENT  = 0;
    localparam int BIT_WRITABLE = 1;
    localparam int BIT_USER     = 2;
    localparam int COW_BIT      = 9;

    // action codes
    localparam logic [1:0] ACT_MAP       = 2'd0;
    localparam logic [1:0] ACT_TRANSLATE = 2'd1;
    localparam logic [1:0] ACT_FAULT     = 2'd2;

    // status codes
    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_NOT_MAPPED = 3'd1;
    localparam logic [2:0] ST_COW        = 3'd2;
    localparam logic [2:0] ST_UNHANDLED  = 3'd3;
    localparam logic [2:0] ST_NO_FRAME   = 3'd4;
    localparam logic [2:0] ST_RANGE      = 3'd5;

endpackage
`default_nettype wire

// File: hw/rtl/two_level_page_table_cow_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_page_table_cow_core: two-level page table with copy-on-write
// map, translate and write-fault resolution over one entry memory
// ----------------------------------------------------------------------------
// Each transaction passes through S_IDLE, which accepts it and issues the
// entry read, and S_EXEC, which modifies and writes the entry back and loads
// the result register; a new transaction is taken only back in S_IDLE, once
// the last is through. The first map into a table whose present bit is clear
// first sweeps that table's 1024 entries to zero through the single write
// port, one entry a cycle with the last held until the result register is
// free, writing the new entry during the sweep. The result register lets the
// next transaction be accepted while a result still waits downstream; the
// modify cycle stalls only if the previous result has not yet been taken.
module two_level_page_table_cow_core #(
    parameter int TABLES = tlpt_pkg::DEF_TABLES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_virt_addr,
    input  wire logic [31:0] i_phys_addr,
    input  wire logic [11:0] i_entry_flags,
    input  wire logic        i_fault_present,
    input  wire logic        i_fault_write,
    input  wire logic [31:0] i_new_frame_addr,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [31:0]      o_result_addr,
    output logic [31:0]      o_copy_from_addr,
    output logic             o_tlb_invalidate
);
    import tlpt_pkg::*;

    localparam int TW    = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam int AW    = TW + IDX_W;
    localparam int DEPTH = TABLES * ENTRIES_PER_TABLE;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES_PER_TABLE - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CLEAR
    } t_state;

    t_state              r_state;
    logic [1:0]          r_action;
    logic [31:0]         r_virt;
    logic [19:0]         r_frame;
    logic [11:0]         r_flags;
    logic                r_fp;
    logic                r_fw;
    logic [31:0]         r_new_frame;
    logic [IDX_W-1:0]    r_cnt;
    logic [TABLES-1:0]   r_present;
    logic                r_o_valid;
    logic [2:0]          r_o_status;
    logic [31:0]         r_o_result;
    logic [31:0]         r_o_copy;
    logic                r_o_inv;

    // entry memory
    logic [31:0]         mem [DEPTH];
    logic [31:0]         r_rd;

    logic                accept;
    logic                out_free;
    logic [9:0]          dir;
    logic [TW-1:0]       dir_t;
    logic [IDX_W-1:0]    idx;
    logic                in_pool;
    logic                tbl;
    logic [31:0]         map_entry;
    logic                cow_hit;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [31:0]         mem_wd;
    logic [AW-1:0]       mem_ra;
    logic                res_load;
    logic [2:0]          n_status;
    logic [31:0]         n_result;
    logic [31:0]         n_copy;
    logic                n_inv;
    logic                start_clear;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;

    // field decode of the held transaction
    assign dir       = r_virt[31:DIR_SHIFT];
    assign dir_t     = dir[TW-1:0];
    assign idx       = r_virt[DIR_SHIFT-1:OFFSET_W];
    assign in_pool   = {1'b0, dir} < 11'(TABLES);
    assign tbl       = in_pool && r_present[dir_t];
    assign map_entry = {r_frame, r_flags};
    assign cow_hit   = r_fp && r_fw && tbl && r_rd[BIT_PRESENT] && r_rd[COW_BIT];
    assign mem_ra    = {i_virt_addr[DIR_SHIFT+TW-1:DIR_SHIFT],
                        i_virt_addr[DIR_SHIFT-1:OFFSET_W]};

    // modify step: result, write-back and sweep start
    always_comb begin
        mem_we      = 1'b0;
        mem_wa      = {dir_t, idx};
        mem_wd      = map_entry;
        res_load    = 1'b0;
        start_clear = 1'b0;
        n_status    = ST_UNHANDLED;
        n_result    = '0;
        n_copy      = '0;
        n_inv       = 1'b0;
        case (r_state)
            S_EXEC: begin
                if (out_free) begin
                    res_load = 1'b1;
                    case (r_action)
                        ACT_MAP: begin
                            if (!in_pool) begin
                                n_status = ST_RANGE;
                            end else if (!tbl) begin
                                res_load    = 1'b0;
                                start_clear = 1'b1;
                            end else begin
                                mem_we   = 1'b1;
                                n_status = ST_DONE;
                                n_inv    = 1'b1;
                            end
                        end
                        ACT_TRANSLATE: begin
                            if (tbl && r_rd[BIT_PRESENT]) begin
                                n_status = ST_DONE;
                                n_result = {r_rd[31:OFFSET_W], r_virt[OFFSET_W-1:0]};
                            end else begin
                                n_status = ST_NOT_MAPPED;
                            end
                        end
                        ACT_FAULT: begin
                            if (cow_hit && (r_new_frame == '0)) begin
                                n_status = ST_NO_FRAME;
                            end else if (cow_hit) begin
                                mem_we   = 1'b1;
                                mem_wd   = {r_new_frame[31:OFFSET_W], 9'd0,
                                            r_rd[BIT_USER], 2'b11};
                                n_status = ST_COW;
                                n_copy   = {r_rd[31:OFFSET_W], 12'd0};
                                n_inv    = 1'b1;
                            end else begin
                                n_status = ST_UNHANDLED;
                            end
                        end
                        default: begin
                            n_status = ST_UNHANDLED;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                // zero sweep, the new entry lands at its own index
                mem_wa = {dir_t, r_cnt};
                mem_wd = (r_cnt == idx) ? map_entry : 32'd0;
                if (r_cnt != LAST_IDX) begin
                    mem_we = 1'b1;
                end else if (out_free) begin
                    mem_we   = 1'b1;
                    res_load = 1'b1;
                    n_status = ST_DONE;
                    n_inv    = 1'b1;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // entry memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (accept) begin
            r_rd <= mem[mem_ra];
        end
    end

    // state, directory present bits and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= '0;
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (start_clear) begin
                        r_state <= S_CLEAR;
                        r_cnt   <= '0;
                    end else if (res_load) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CLEAR: begin
                    if (r_cnt != LAST_IDX) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (res_load) begin
                        r_present[dir_t] <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (res_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (res_load) begin
                r_o_status <= n_status;
                r_o_result <= n_result;
                r_o_copy   <= n_copy;
                r_o_inv    <= n_inv;
            end
        end
    end

    // held transaction fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action    <= i_action;
            r_virt      <= i_virt_addr;
            r_frame     <= i_phys_addr[31:OFFSET_W];
            r_flags     <= i_entry_flags;
            r_fp        <= i_fault_present;
            r_fw        <= i_fault_write;
            r_new_frame <= i_new_frame_addr;
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_result_addr    = r_o_result;
    assign o_copy_from_addr = r_o_copy;
    assign o_tlb_invalidate = r_o_inv;

`ifndef SYNTHESIS
    // an accepted transaction moves straight to the modify step
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted transaction did not enter modify step");

    // sweep counter steps by one each cycle until the last entry
    a_sweep_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) && (r_cnt != LAST_IDX)
        |=> (r_state == S_CLEAR) && (r_cnt == $past(r_cnt) + 1'b1))
        else $error("table sweep counter skipped");

    // write-back outside the sweep only lands in a present table
    a_write_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && (r_state == S_EXEC) |-> r_present[dir_t])
        else $error("entry written in a table that is not present");

    // a resolved copy-on-write always asks for a tlb drop
    a_cow_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_COW) |-> o_tlb_invalidate)
        else $error("cow result without tlb invalidate");
`endif

endmodule
`default_nettype wire
